FILE: hw/rtl/hcm_pkg.sv
// types, codes and hall lookup tables for the six-step commutator
package hcm_pkg;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned HALL_W  = 3;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned ADDR_W  = 2;
  localparam int unsigned SIDES   = 3;
  localparam int unsigned NLEVELS = 2 * SIDES;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 136;

  localparam logic [MODE_W-1:0] MODE_HALL     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_THROTTLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POSITION = 2'd2;

  localparam logic [ADDR_W-1:0] REG_BRAKE_ENABLE   = 2'd0;
  localparam logic [ADDR_W-1:0] REG_HIGH_OFF_LEVEL = 2'd1;
  localparam logic [ADDR_W-1:0] REG_LOW_ON_LEVEL   = 2'd2;
  localparam logic [ADDR_W-1:0] REG_LOW_OFF_LEVEL  = 2'd3;

  localparam logic [PHASE_W-1:0] PHASE_INVALID = 3'd7;
  localparam logic [PHASE_W-1:0] PHASE_RESET   = 3'd1;

  typedef logic [NLEVELS-1:0][LEVEL_W-1:0] hcm_levels_t;

  // bit 0 is side a, bit 2 is side c
  typedef struct packed {
    logic [SIDES-1:0] lo;
    logic [SIDES-1:0] hi;
  } hcm_sides_t;

  typedef struct packed {
    logic                    brake_enable;
    logic [LEVEL_W-1:0]      high_off_level;
    logic [LEVEL_W-1:0]      low_on_level;
    logic [LEVEL_W-1:0]      low_off_level;
  } hcm_cfg_t;

  typedef struct packed {
    logic                    updated;
    logic [HALL_W-1:0]       hall;
    logic signed [THR_W-1:0] thr;
  } hcm_comm_t;

  function automatic logic [PHASE_W-1:0] hcm_phase_of_hall(input logic [HALL_W-1:0] hall);
    logic [PHASE_W-1:0] ph;
    case (hall)
      3'd1:    ph = 3'd2;
      3'd2:    ph = 3'd4;
      3'd3:    ph = 3'd3;
      3'd4:    ph = 3'd6;
      3'd5:    ph = 3'd1;
      3'd6:    ph = 3'd5;
      default: ph = PHASE_INVALID;
    endcase
    return ph;
  endfunction

  function automatic hcm_sides_t hcm_fwd_sides(input logic [HALL_W-1:0] hall);
    hcm_sides_t s;
    case (hall)
      3'd1:    s = '{lo: 3'b100, hi: 3'b001};
      3'd2:    s = '{lo: 3'b001, hi: 3'b010};
      3'd3:    s = '{lo: 3'b100, hi: 3'b010};
      3'd4:    s = '{lo: 3'b010, hi: 3'b100};
      3'd5:    s = '{lo: 3'b010, hi: 3'b001};
      3'd6:    s = '{lo: 3'b001, hi: 3'b100};
      default: s = '{lo: 3'b000, hi: 3'b000};
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/hcm_commutate.sv
// hall decode, commutation decision and position counter update
module hcm_commutate import hcm_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  logic [MODE_W-1:0]            mode,
  input  logic [HALL_W-1:0]            hall,
  input  logic signed [THR_W-1:0]      thr_in,
  input  logic signed [POS_W-1:0]      pos_in,
  input  logic [PHASE_W-1:0]           last_phase,
  input  logic [POSITION_BITS-1:0]     pos_cnt,
  input  logic signed [THR_W-1:0]      throttle_held,
  output logic [PHASE_W-1:0]           phase,
  output logic [PHASE_W-1:0]           last_phase_nxt,
  output logic [POSITION_BITS-1:0]     pos_cnt_nxt,
  output logic signed [THR_W-1:0]      throttle_nxt,
  output hcm_comm_t                    comm
);

  localparam logic signed [3:0] D_MAX = 4'sd4;

  logic               force_comm;
  logic               is_comm;
  logic               commit;
  logic               step_ok;
  logic signed [3:0]  d_raw;
  logic signed [3:0]  d_adj;
  logic signed [63:0] pos_wr_ext;

  assign phase      = hcm_phase_of_hall(hall);
  assign force_comm = (mode == MODE_THROTTLE);
  assign is_comm    = (mode == MODE_HALL) || force_comm;
  assign commit     = is_comm &&
                      (force_comm || ((phase != last_phase) && (phase != PHASE_INVALID)));
  assign step_ok    = (phase != PHASE_INVALID) && (last_phase != PHASE_INVALID);
  assign throttle_nxt = force_comm ? thr_in : throttle_held;

  // wrapped phase difference
  always_comb begin
    d_raw = $signed({1'b0, phase}) - $signed({1'b0, last_phase});
    if (d_raw > D_MAX) begin
      d_adj = D_MAX - d_raw;
    end else if (d_raw < -D_MAX) begin
      d_adj = -D_MAX - d_raw;
    end else begin
      d_adj = d_raw;
    end
  end

  assign pos_wr_ext = 64'(pos_in);

  always_comb begin
    pos_cnt_nxt = pos_cnt;
    if (mode == MODE_POSITION) begin
      pos_cnt_nxt = pos_wr_ext[POSITION_BITS-1:0];
    end else if (commit && step_ok) begin
      pos_cnt_nxt = pos_cnt + (POSITION_BITS)'(d_adj);
    end
  end

  assign last_phase_nxt = commit ? phase : last_phase;

  assign comm.updated = commit;
  assign comm.hall    = hall;
  assign comm.thr     = throttle_nxt;

endmodule

FILE: hw/rtl/hcm_drive.sv
// half-bridge level selection from throttle, direction and hall code
module hcm_drive import hcm_pkg::*; #(
  parameter int THROTTLE_LIMIT = 4096
) (
  input  hcm_comm_t   comm,
  input  hcm_cfg_t    cfg,
  input  hcm_levels_t levels_in,
  output hcm_levels_t levels_nxt
);

  localparam logic signed [THR_W+1:0] LIMIT = (THR_W+2)'(THROTTLE_LIMIT);

  logic signed [THR_W+1:0] thr_ext;
  logic                    in_range;
  logic                    rev;
  logic [LEVEL_W-1:0]      mag;
  hcm_sides_t              fwd;
  hcm_sides_t              sides;

  assign thr_ext  = (THR_W+2)'(comm.thr);
  assign in_range = ((thr_ext > 0) && (thr_ext < LIMIT)) ||
                    ((thr_ext < 0) && (thr_ext > -LIMIT));
  assign rev      = comm.thr[THR_W-1];
  assign mag      = rev ? LEVEL_W'(-comm.thr) : LEVEL_W'(comm.thr);
  assign fwd      = hcm_fwd_sides(comm.hall);

  // reverse swaps high and low sides
  assign sides.lo = rev ? fwd.hi : fwd.lo;
  assign sides.hi = rev ? fwd.lo : fwd.hi;

  always_comb begin
    levels_nxt = levels_in;
    if (comm.updated) begin
      for (int k = 0; k < SIDES; k++) begin
        if (in_range && sides.hi[k]) begin
          levels_nxt[2*k]   = mag;
          levels_nxt[2*k+1] = mag;
        end else if (in_range) begin
          levels_nxt[2*k]   = cfg.high_off_level;
          levels_nxt[2*k+1] = sides.lo[k] ? cfg.low_on_level : cfg.low_off_level;
        end else begin
          levels_nxt[2*k]   = cfg.high_off_level;
          levels_nxt[2*k+1] = cfg.brake_enable ? cfg.low_on_level : cfg.low_off_level;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/hall_six_step_commutator.sv
// top level of the six-step hall commutator: registers, handshake and config
//
// in_* carries one beat per event: a hall edge, a throttle write that forces a
// commutation, or a position counter write, selected by in_tuser. Every beat
// yields exactly one out_* beat with the decoded hall phase, a flag that the
// bridge levels were recomputed, the six bridge PWM levels and the position
// count after that event.
// A beat is taken into an input register, then decoded, commutated and
// written to the output register. Throughput is one beat per cycle while
// the output is not stalled, and the state update loop on phase, count and
// levels, which updates with each beat, does not limit it.
// When out_tready is low the output register holds its beat and the input
// register holds one more; in_tready falls only once both are full.
// Reset clears both registers, sets the last phase to 1, the count and
// throttle to zero, all bridge levels to zero and the config registers to
// their defaults. cfg_* writes one register per cycle with cfg_we, and is
// meant to be used only while no beat is in flight.
module hall_six_step_commutator import hcm_pkg::*; #(
  parameter int THROTTLE_LIMIT = 4096,
  parameter int POSITION_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // hall_bits[2:0], throttle_value[18:3], position_value[50:19], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // drive_updated[0], hall_phase[3:1], a_high_level[19:4], a_low_level[35:20],
  // b_high_level[51:36], b_low_level[67:52], c_high_level[83:68],
  // c_low_level[99:84], position_count[131:100], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [ADDR_W-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic                     s1_valid_r;
  logic [MODE_W-1:0]        s1_mode_r;
  logic [HALL_W-1:0]        s1_hall_r;
  logic signed [THR_W-1:0]  s1_thr_r;
  logic signed [POS_W-1:0]  s1_pos_r;

  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [OUT_DATA_W-1:0]    out_data_nxt;

  logic [PHASE_W-1:0]       last_phase_r;
  logic [PHASE_W-1:0]       last_phase_nxt;
  logic [POSITION_BITS-1:0] pos_cnt_r;
  logic [POSITION_BITS-1:0] pos_cnt_nxt;
  logic signed [THR_W-1:0]  throttle_r;
  logic signed [THR_W-1:0]  throttle_nxt;
  hcm_levels_t              levels_r;
  hcm_levels_t              levels_nxt;
  hcm_cfg_t                 cfg_r;

  logic [PHASE_W-1:0]       phase;
  hcm_comm_t                comm;
  logic signed [POSITION_BITS-1:0] pos_cnt_s;
  logic signed [63:0]       pos_out_ext;
  logic                     advance;
  logic                     in_fire;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  hcm_commutate #(
    .POSITION_BITS(POSITION_BITS)
  ) u_comm (
    .mode          (s1_mode_r),
    .hall          (s1_hall_r),
    .thr_in        (s1_thr_r),
    .pos_in        (s1_pos_r),
    .last_phase    (last_phase_r),
    .pos_cnt       (pos_cnt_r),
    .throttle_held (throttle_r),
    .phase         (phase),
    .last_phase_nxt(last_phase_nxt),
    .pos_cnt_nxt   (pos_cnt_nxt),
    .throttle_nxt  (throttle_nxt),
    .comm          (comm)
  );

  hcm_drive #(
    .THROTTLE_LIMIT(THROTTLE_LIMIT)
  ) u_drive (
    .comm      (comm),
    .cfg       (cfg_r),
    .levels_in (levels_r),
    .levels_nxt(levels_nxt)
  );

  assign pos_cnt_s   = $signed(pos_cnt_nxt);
  assign pos_out_ext = 64'(pos_cnt_s);

  assign out_data_nxt = {4'd0, pos_out_ext[POS_W-1:0],
                         levels_nxt[5], levels_nxt[4], levels_nxt[3],
                         levels_nxt[2], levels_nxt[1], levels_nxt[0],
                         phase, comm.updated};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_tuser;
      s1_hall_r <= in_tdata[2:0];
      s1_thr_r  <= $signed(in_tdata[18:3]);
      s1_pos_r  <= $signed(in_tdata[50:19]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // commutator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_phase_r <= PHASE_RESET;
      pos_cnt_r    <= '0;
      throttle_r   <= '0;
      levels_r     <= '0;
    end else if (advance) begin
      last_phase_r <= last_phase_nxt;
      pos_cnt_r    <= pos_cnt_nxt;
      throttle_r   <= throttle_nxt;
      levels_r     <= levels_nxt;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brake_enable   <= 1'b0;
      cfg_r.high_off_level <= '0;
      cfg_r.low_on_level   <= '1;
      cfg_r.low_off_level  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BRAKE_ENABLE:   cfg_r.brake_enable   <= cfg_wdata[0];
        REG_HIGH_OFF_LEVEL: cfg_r.high_off_level <= cfg_wdata;
        REG_LOW_ON_LEVEL:   cfg_r.low_on_level   <= cfg_wdata;
        REG_LOW_OFF_LEVEL:  cfg_r.low_off_level  <= cfg_wdata;
        default:            cfg_r.brake_enable   <= cfg_r.brake_enable;
      endcase
    end
  end

endmodule

FILE: hw/rtl/hcm_checker.sv
// port-level checks for the six-step commutator and their binding
module hcm_checker import hcm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // decoded phase is never zero
  a_phase_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:1] != 3'd0)
    else $error("hall_phase zero on result beat");

  // a beat accepted while the output register is empty always reaches out_tvalid through the input register
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("accepted beat did not reach output");

endmodule

bind hall_six_step_commutator hcm_checker u_hcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench for the six-step hall commutator: queued beats checked against a commutation model
module tb;
  import hcm_pkg::*;

  localparam int THROTTLE_LIM  = 4096;
  localparam int RUNS          = 6;
  localparam int ITEMS_PER_RUN = 125;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // indexed by hall code, hall 7 first
  localparam logic [7:0][PHASE_W-1:0] PHASE_LUT =
    {PHASE_INVALID, 3'd5, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, PHASE_INVALID};
  localparam logic [7:0][2:0] FWD_HI =
    {3'b000, 3'b100, 3'b001, 3'b100, 3'b010, 3'b010, 3'b001, 3'b000};
  localparam logic [7:0][2:0] FWD_LO =
    {3'b000, 3'b001, 3'b010, 3'b010, 3'b100, 3'b001, 3'b100, 3'b000};
  // indexed by phase, phase 6 first
  localparam logic [6:0][HALL_W-1:0] HALL_OF_PHASE =
    {3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5, 3'd0};

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic [HALL_W-1:0]       hall;
    logic signed [THR_W-1:0] thr;
    logic signed [POS_W-1:0] pos;
  } motor_event_t;

  typedef struct {
    logic                    updated;
    logic [PHASE_W-1:0]      phase;
    hcm_levels_t             levels;
    logic signed [POS_W-1:0] pos;
  } bridge_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [ADDR_W-1:0]     cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  // model state
  logic                    brake_on = 1'b0;
  logic [LEVEL_W-1:0]      high_off = '0;
  logic [LEVEL_W-1:0]      low_on = '1;
  logic [LEVEL_W-1:0]      low_off = '0;
  logic [PHASE_W-1:0]      last_phase = PHASE_RESET;
  logic signed [POS_W-1:0] pos_count = '0;
  logic signed [THR_W-1:0] thr_held = '0;
  hcm_levels_t             bridge = '0;

  motor_event_t   pending_events[$];
  bridge_result_t expected_bridge[$];
  motor_event_t   head_ev;
  int  in_wait = 0;
  int  out_wait = 0;
  bit  in_quiet = 1'b0;
  bit  out_quiet = 1'b0;
  int  mismatch_count = 0;
  int  result_count = 0;
  int  cycle_count = 0;

  hall_six_step_commutator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic bridge_result_t commutate_model(input motor_event_t ev);
    bridge_result_t     r;
    logic [PHASE_W-1:0] ph;
    logic [2:0]         hi_on;
    logic [2:0]         lo_on;
    logic [LEVEL_W-1:0] mag;
    int                 d;
    int                 t;
    ph = PHASE_LUT[ev.hall];
    r.updated = 1'b0;
    if (ev.mode == MODE_POSITION) begin
      pos_count = ev.pos;
    end else if (ev.mode == MODE_HALL || ev.mode == MODE_THROTTLE) begin
      if (ev.mode == MODE_THROTTLE) thr_held = ev.thr;
      if (ev.mode == MODE_THROTTLE || (ph != last_phase && ph != PHASE_INVALID)) begin
        if (ph != PHASE_INVALID && last_phase != PHASE_INVALID) begin
          d = int'(ph) - int'(last_phase);
          if (d > 4) d = 4 - d;
          else if (d < -4) d = -4 - d;
          pos_count = pos_count + d;
        end
        last_phase = ph;
        r.updated = 1'b1;
        t = int'(thr_held);
        if (t != 0 && t > -THROTTLE_LIM && t < THROTTLE_LIM) begin
          // reverse drive swaps high and low sides
          hi_on = (t < 0) ? FWD_LO[ev.hall] : FWD_HI[ev.hall];
          lo_on = (t < 0) ? FWD_HI[ev.hall] : FWD_LO[ev.hall];
          mag = LEVEL_W'((t < 0) ? -t : t);
          for (int k = 0; k < 3; k++) begin
            if (hi_on[k]) begin
              bridge[2*k]   = mag;
              bridge[2*k+1] = mag;
            end else begin
              bridge[2*k]   = high_off;
              bridge[2*k+1] = lo_on[k] ? low_on : low_off;
            end
          end
        end else begin
          for (int k = 0; k < 3; k++) begin
            bridge[2*k]   = high_off;
            bridge[2*k+1] = brake_on ? low_on : low_off;
          end
        end
      end
    end
    r.phase  = ph;
    r.levels = bridge;
    r.pos    = pos_count;
    return r;
  endfunction

  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 49) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic signed [THR_W-1:0] rand_throttle();
    int pick;
    int mag;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return THR_W'($urandom);
    if (pick == 2) mag = THROTTLE_LIM - 1 + $urandom_range(0, 2);
    else mag = $urandom_range(1, THROTTLE_LIM - 1);
    return $urandom_range(0, 1) ? THR_W'(mag) : THR_W'(-mag);
  endfunction

  task automatic add_event(input logic [MODE_W-1:0] mode, input logic [HALL_W-1:0] hall,
                           input logic [THR_W-1:0] thr, input logic [POS_W-1:0] pos);
    motor_event_t ev;
    ev.mode = mode;
    ev.hall = hall;
    ev.thr  = thr;
    ev.pos  = pos;
    pending_events.push_back(ev);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BRAKE_ENABLE:   brake_on = val[0];
      REG_HIGH_OFF_LEVEL: high_off = val;
      REG_LOW_ON_LEVEL:   low_on = val;
      REG_LOW_OFF_LEVEL:  low_off = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic brake, input logic [CFG_W-1:0] hoff,
                                input logic [CFG_W-1:0] lon, input logic [CFG_W-1:0] loff);
    write_reg(REG_BRAKE_ENABLE, {{(CFG_W-1){1'b0}}, brake});
    write_reg(REG_HIGH_OFF_LEVEL, hoff);
    write_reg(REG_LOW_ON_LEVEL, lon);
    write_reg(REG_LOW_OFF_LEVEL, loff);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_tvalid || expected_bridge.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] beat);
    bridge_result_t want;
    bridge_result_t got;
    bit             bad;
    got.updated = beat[0];
    got.phase   = beat[3:1];
    got.levels  = beat[99:4];
    got.pos     = beat[131:100];
    if (expected_bridge.size() == 0) begin
      if (mismatch_count < 10) $display("out beat with nothing expected: %h", beat);
      mismatch_count++;
      return;
    end
    want = expected_bridge.pop_front();
    bad = (got.updated !== want.updated) || (got.phase !== want.phase) ||
          (got.pos !== want.pos);
    for (int k = 0; k < NLEVELS; k++) if (got.levels[k] !== want.levels[k]) bad = 1'b1;
    if (bad) begin
      if (mismatch_count < 10) begin
        $display("result %0d: expected upd %b phase %0d levels %h pos %h", result_count,
                 want.updated, want.phase, want.levels, want.pos);
        $display("result %0d:      got upd %b phase %0d levels %h pos %h", result_count,
                 got.updated, got.phase, got.levels, got.pos);
      end
      mismatch_count++;
    end
    result_count++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_bridge.push_back(commutate_model(head_ev));
      if (!in_tvalid || in_tready) begin
        if (in_wait > 0 || pending_events.size() == 0) begin
          if (in_wait > 0) in_wait--;
          in_tvalid <= 1'b0;
        end else begin
          head_ev = pending_events.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, head_ev.pos, head_ev.thr, head_ev.hall};
          in_tuser  <= head_ev.mode;
          in_wait = draw_gap(in_quiet);
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
        out_wait = draw_gap(out_quiet);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int cur_ph;
    int dir;
    int r;
    logic [HALL_W-1:0] h;
    logic [POS_W-1:0]  p;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // repeated and invalid edges, forward and reverse drive, throttle limits
    add_event(MODE_HALL, 3'd5, 16'sd0, '0);
    add_event(MODE_HALL, 3'd0, 16'sd0, '0);
    add_event(MODE_HALL, 3'd7, 16'sd0, '0);
    add_event(MODE_THROTTLE, 3'd1, 16'sd100, '0);
    add_event(MODE_HALL, 3'd3, 16'sd0, '0);
    add_event(MODE_HALL, 3'd3, 16'sd0, '0);
    add_event(MODE_THROTTLE, 3'd3, -16'sd100, '0);
    add_event(MODE_HALL, 3'd1, 16'sd0, '0);
    add_event(MODE_THROTTLE, 3'd1, 16'sd4095, '0);
    add_event(MODE_THROTTLE, 3'd1, -16'sd4095, '0);
    add_event(MODE_THROTTLE, 3'd1, 16'sd4096, '0);
    add_event(MODE_THROTTLE, 3'd1, -16'sd4096, '0);
    add_event(MODE_THROTTLE, 3'd1, 16'h7fff, '0);
    add_event(MODE_THROTTLE, 3'd1, 16'h8000, '0);
    add_event(MODE_THROTTLE, 3'd1, 16'sd0, '0);
    add_event(MODE_THROTTLE, 3'd5, 16'sd1, '0);
    // wrapped phase steps
    add_event(MODE_HALL, 3'd4, 16'sd0, '0);
    add_event(MODE_HALL, 3'd5, 16'sd0, '0);
    add_event(MODE_HALL, 3'd6, 16'sd0, '0);
    add_event(MODE_HALL, 3'd5, 16'sd0, '0);
    // counter wrap both ways
    add_event(MODE_POSITION, 3'd0, 16'sd0, 32'h7fff_ffff);
    add_event(MODE_HALL, 3'd1, 16'sd0, '0);
    add_event(MODE_POSITION, 3'd7, 16'sd0, 32'h8000_0000);
    add_event(MODE_HALL, 3'd5, 16'sd0, '0);
    // forced invalid phase, then recovery without a step
    add_event(MODE_THROTTLE, 3'd0, -16'sd1, '0);
    add_event(MODE_HALL, 3'd2, 16'sd0, '0);
    add_event(MODE_UNUSED, 3'd6, -16'sd1, '1);
    wait_idle();

    for (int run = 0; run < RUNS; run++) begin
      case (run)
        0: apply_settings(1'b1, 16'h0000, 16'hffff, 16'h0000);
        1: apply_settings(1'b0, 16'hffff, 16'h0000, 16'hffff);
        2: apply_settings(1'b1, 16'hffff, 16'h0000, 16'hffff);
        default: apply_settings(1'($urandom_range(0, 1)), CFG_W'($urandom_range(0, 65535)),
                                CFG_W'($urandom_range(0, 65535)),
                                CFG_W'($urandom_range(0, 65535)));
      endcase
      cur_ph = $urandom_range(1, 6);
      dir = $urandom_range(0, 1) ? 1 : -1;
      add_event(MODE_THROTTLE, HALL_OF_PHASE[cur_ph], rand_throttle(), $urandom);
      for (int n = 1; n < ITEMS_PER_RUN; n++) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 29) == 0) dir = -dir;
        if (r < 60) begin
          cur_ph = cur_ph + dir;
          if (cur_ph > 6) cur_ph = 1;
          if (cur_ph < 1) cur_ph = 6;
          add_event(MODE_HALL, HALL_OF_PHASE[cur_ph], THR_W'($urandom), $urandom);
        end else if (r < 70) begin
          h = HALL_W'($urandom_range(0, 7));
          if (PHASE_LUT[h] != PHASE_INVALID) cur_ph = int'(PHASE_LUT[h]);
          add_event(MODE_HALL, h, THR_W'($urandom), $urandom);
        end else if (r < 82) begin
          h = ($urandom_range(0, 4) == 0) ? HALL_W'($urandom_range(0, 7))
                                          : HALL_OF_PHASE[cur_ph];
          if (PHASE_LUT[h] != PHASE_INVALID) cur_ph = int'(PHASE_LUT[h]);
          add_event(MODE_THROTTLE, h, rand_throttle(), $urandom);
        end else if (r < 90) begin
          case ($urandom_range(0, 3))
            0: p = 32'h7fff_ffff - $urandom_range(0, 8);
            1: p = 32'h8000_0000 + $urandom_range(0, 8);
            default: p = $urandom;
          endcase
          add_event(MODE_POSITION, HALL_W'($urandom_range(0, 7)), THR_W'($urandom), p);
        end else if (r < 94) begin
          add_event(MODE_UNUSED, HALL_W'($urandom_range(0, 7)), THR_W'($urandom),
                    $urandom);
        end else begin
          add_event(MODE_HALL, HALL_OF_PHASE[cur_ph], THR_W'($urandom), $urandom);
        end
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_bridge.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: hall_six_step_commutator.f
hw/rtl/hcm_pkg.sv
hw/rtl/hcm_commutate.sv
hw/rtl/hcm_drive.sv
hw/rtl/hall_six_step_commutator.sv
hw/rtl/hcm_checker.sv
tb/sv/tb.sv
